// File: rtl/mdst_pkg.sv
// ----------------------------------------------------------------------------
// mdst_pkg
// Shared types, opcodes, defaults and the note period table for the
// multi-drive step tone generator.
// ----------------------------------------------------------------------------
package mdst_pkg;

  typedef logic [2:0]  opcode_t;
  typedef logic [3:0]  channel_t;
  typedef logic [7:0]  note_t;
  typedef logic [15:0] period_t;
  typedef logic [6:0]  position_t;
  typedef logic [7:0]  drive_bits_t;

  localparam opcode_t OP_TICK     = 3'd0;
  localparam opcode_t OP_NOTE_ON  = 3'd1;
  localparam opcode_t OP_NOTE_OFF = 3'd2;
  localparam opcode_t OP_RAW_NOTE = 3'd3;
  localparam opcode_t OP_PERIOD   = 3'd4;
  localparam opcode_t OP_DIR      = 3'd5;
  localparam opcode_t OP_HOME     = 3'd6;

  localparam int DEF_DRIVE_COUNT  = 8;
  localparam int DEF_MAX_POSITION = 80;
  localparam int OUT_BITS         = 8;

  localparam logic signed [9:0] TOP_NOTE = 10'sd48;

  localparam period_t TONE_TABLE [128] = '{
    16'd727, 16'd727, 16'd686, 16'd648, 16'd612, 16'd577, 16'd545, 16'd514,
    16'd485, 16'd458, 16'd432, 16'd408, 16'd385, 16'd364, 16'd343, 16'd324,
    16'd306, 16'd289, 16'd272, 16'd257, 16'd243, 16'd229, 16'd216, 16'd204,
    16'd193, 16'd182, 16'd172, 16'd162, 16'd153, 16'd144, 16'd136, 16'd129,
    16'd121, 16'd115, 16'd108, 16'd102, 16'd96,  16'd91,  16'd86,  16'd81,
    16'd76,  16'd72,  16'd68,  16'd64,  16'd61,  16'd57,  16'd54,  16'd51,
    16'd48,  16'd48,  16'd48,  16'd48,  16'd48,  16'd48,  16'd48,  16'd48,
    16'd48,  16'd48,  16'd48,  16'd48,  16'd48,  16'd550, 16'd542, 16'd534,
    16'd526, 16'd518, 16'd510, 16'd503, 16'd495, 16'd487, 16'd479, 16'd471,
    16'd463, 16'd455, 16'd447, 16'd440, 16'd432, 16'd424, 16'd416, 16'd408,
    16'd400, 16'd392, 16'd384, 16'd377, 16'd369, 16'd361, 16'd353, 16'd345,
    16'd337, 16'd329, 16'd321, 16'd314, 16'd306, 16'd298, 16'd290, 16'd282,
    16'd274, 16'd266, 16'd258, 16'd251, 16'd243, 16'd235, 16'd227, 16'd219,
    16'd211, 16'd203, 16'd195, 16'd188, 16'd180, 16'd172, 16'd164, 16'd156,
    16'd148, 16'd140, 16'd132, 16'd125, 16'd117, 16'd109, 16'd101, 16'd93,
    16'd85,  16'd77,  16'd69,  16'd62,  16'd54,  16'd46,  16'd38,  16'd30
  };

endpackage

// File: rtl/multi_drive_step_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// multi_drive_step_tone_generator_unit
// Stepper drive tone generator: per-drive period, tick counter, head position
// and direction, driven by tick, note and control requests.
// A request is held in the input register, and its result strobe comes from the result register.
// Throughput: one request per cycle; busy stays low, set by the single
// input register to result register pass with all drives updated in parallel.
// Reset (rst, synchronous): all drives disabled, counters and heads at zero,
// direction backward, note offset zero, no result pending.
// ----------------------------------------------------------------------------
module multi_drive_step_tone_generator_unit #(
  parameter int DRIVE_COUNT  = mdst_pkg::DEF_DRIVE_COUNT,
  parameter int MAX_POSITION = mdst_pkg::DEF_MAX_POSITION
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  mdst_pkg::opcode_t     opcode,
  input  mdst_pkg::channel_t    channel,
  input  mdst_pkg::note_t       note_number,
  input  mdst_pkg::period_t     period_value,
  input  logic                  forward_flag,
  input  logic                  cfg_write,
  input  logic [7:0]            cfg_data,
  output logic                  done,
  output mdst_pkg::drive_bits_t step_pulses,
  output mdst_pkg::drive_bits_t direction_levels
);
  import mdst_pkg::*;

  localparam int        OUT_N    = (DRIVE_COUNT < OUT_BITS) ? DRIVE_COUNT : OUT_BITS;
  localparam position_t MAX_POS  = 7'(MAX_POSITION);
  localparam logic [4:0] DRIVES5 = 5'(DRIVE_COUNT);

  logic        item_valid;
  opcode_t     op_q;
  channel_t    channel_q;
  note_t       note_q;
  period_t     period_q;
  logic        fwd_q;

  logic signed [7:0] note_offset;

  period_t   step_period   [DRIVE_COUNT];
  period_t   tick_count    [DRIVE_COUNT];
  position_t head_position [DRIVE_COUNT];
  logic [DRIVE_COUNT-1:0] moving_forward;

  period_t   period_next [DRIVE_COUNT];
  period_t   count_next  [DRIVE_COUNT];
  position_t pos_next    [DRIVE_COUNT];
  logic [DRIVE_COUNT-1:0] fwd_next;
  logic [DRIVE_COUNT-1:0] pulses_next;

  period_t   tick_cnt [DRIVE_COUNT];
  position_t tick_pos [DRIVE_COUNT];
  logic [DRIVE_COUNT-1:0] tick_fwd;
  logic [DRIVE_COUNT-1:0] fire;
  logic [DRIVE_COUNT-1:0] sel;

  logic              ch_ok;
  logic              note_ok;
  logic signed [9:0] note_sum;
  logic [5:0]        note_clamped;
  period_t           note_on_period;
  period_t           raw_period;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q      <= opcode;
      channel_q <= channel;
      note_q    <= note_number;
      period_q  <= period_value;
      fwd_q     <= forward_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_offset <= '0;
    end else if (cfg_write) begin
      note_offset <= signed'(cfg_data);
    end
  end

  assign ch_ok    = {1'b0, channel_q} < DRIVES5;
  assign note_ok  = !note_q[7];
  assign note_sum = signed'({2'b00, note_q}) + signed'({{2{note_offset[7]}}, note_offset});

  always_comb begin
    priority if (note_sum < 10'sd0) begin
      note_clamped = 6'd0;
    end else if (note_sum > TOP_NOTE) begin
      note_clamped = 6'(TOP_NOTE);
    end else begin
      note_clamped = note_sum[5:0];
    end
  end

  assign note_on_period = TONE_TABLE[{1'b0, note_clamped}];
  assign raw_period     = TONE_TABLE[note_q[6:0]];

  for (genvar d = 0; d < DRIVE_COUNT; d++) begin : g_drive
    period_t cnt_inc;
    logic    dir;

    assign sel[d]   = ch_ok && (channel_q == 4'(d));
    assign cnt_inc  = (tick_count[d] != '1) ? tick_count[d] + 16'd1 : tick_count[d];
    assign fire[d]  = (step_period[d] != '0) && (cnt_inc >= step_period[d]);
    assign dir      = (head_position[d] == MAX_POS) ? 1'b0 :
                      (head_position[d] == 7'd0)    ? 1'b1 : moving_forward[d];
    assign tick_cnt[d] = (step_period[d] == '0) ? tick_count[d] :
                         fire[d]                ? '0 : cnt_inc;
    assign tick_fwd[d] = fire[d] ? dir : moving_forward[d];
    assign tick_pos[d] = !fire[d] ? head_position[d] :
                         dir      ? head_position[d] + 7'd1 : head_position[d] - 7'd1;
  end

  always_comb begin
    period_next = step_period;
    count_next  = tick_count;
    pos_next    = head_position;
    fwd_next    = moving_forward;
    pulses_next = '0;
    unique case (op_q)
      OP_TICK: begin
        count_next  = tick_cnt;
        pos_next    = tick_pos;
        fwd_next    = tick_fwd;
        pulses_next = fire;
      end
      OP_NOTE_ON: begin
        for (int d = 0; d < DRIVE_COUNT; d++) begin
          if (sel[d] && note_ok) period_next[d] = note_on_period;
        end
      end
      OP_NOTE_OFF: begin
        for (int d = 0; d < DRIVE_COUNT; d++) begin
          if (sel[d]) period_next[d] = '0;
        end
      end
      OP_RAW_NOTE: begin
        for (int d = 0; d < DRIVE_COUNT; d++) begin
          if (sel[d] && note_ok) period_next[d] = raw_period;
        end
      end
      OP_PERIOD: begin
        for (int d = 0; d < DRIVE_COUNT; d++) begin
          if (sel[d]) period_next[d] = period_q;
        end
      end
      OP_DIR: begin
        for (int d = 0; d < DRIVE_COUNT; d++) begin
          if (sel[d]) fwd_next[d] = fwd_q;
        end
      end
      OP_HOME: begin
        for (int d = 0; d < DRIVE_COUNT; d++) begin
          fwd_next[d] = 1'b1;
          pos_next[d] = MAX_POS;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DRIVE_COUNT; d++) begin
        step_period[d]   <= '0;
        tick_count[d]    <= '0;
        head_position[d] <= '0;
      end
      moving_forward <= '0;
      done           <= 1'b0;
    end else begin
      done <= item_valid;
      if (item_valid) begin
        step_period    <= period_next;
        tick_count     <= count_next;
        head_position  <= pos_next;
        moving_forward <= fwd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      step_pulses      <= OUT_BITS'(pulses_next[OUT_N-1:0]);
      direction_levels <= OUT_BITS'(fwd_next[OUT_N-1:0]);
    end
  end

`ifndef SYNTHESIS
  localparam drive_bits_t DIR_MASK = OUT_BITS'({OUT_N{1'b1}});

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without result two cycles on");

  a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (item_valid && op_q != OP_TICK) |=> (step_pulses == '0))
    else $error("step pulse on a non-tick request");

  a_home_forward: assert property (@(posedge clk) disable iff (rst)
    (item_valid && op_q == OP_HOME) |=> ((direction_levels & DIR_MASK) == DIR_MASK))
    else $error("home left a drive backward");

  a_disabled_silent: assert property (@(posedge clk) disable iff (rst)
    (item_valid && op_q == OP_TICK && step_period[0] == '0) |=> !step_pulses[0])
    else $error("disabled drive stepped");
`endif

endmodule
